[hdl/tse_pkg.sv]
// Shared types and constants for the table search engine.
// Used by every module of the block but tse_ram; depends on nothing.
`timescale 1ns / 1ps

package tse_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = 6;
    localparam int WORD_W      = 32;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_LINEAR = 2'd1,
        FUNC_BINARY = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMPARE,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [1:0]               func;
        logic [4:0]               entry_index;
        logic signed [WORD_W-1:0] entry_value;
        logic signed [WORD_W-1:0] search_key;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [4:0] position;
        logic [5:0] comparisons;
    } out_item_t;

    // Outcome of one probe from the shared comparator
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_t;

endpackage

[hdl/tse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/tse_cmp.sv]
// Shared key comparator: signed equality and less-than of one entry against the key.
// Depends on tse_pkg.
`timescale 1ns / 1ps

module tse_cmp (
    input  logic signed [tse_pkg::WORD_W-1:0] entry,
    input  logic signed [tse_pkg::WORD_W-1:0] key,
    output tse_pkg::cmp_t                     result
);

    always_comb
    begin
        result.eq = (entry == key);
        result.lt = (entry < key);
    end

endmodule

[hdl/tse_ctrl.sv]
// Search sequencer: bounds, probe pointer, comparison count and output word register.
// Depends on tse_pkg; drives the table RAM read port and the shared comparator.
`timescale 1ns / 1ps

module tse_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tse_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tse_pkg::out_item_t                out_data,
    input  logic [tse_pkg::LEN_W-1:0]         search_len,
    output logic                              rd_en,
    output logic [tse_pkg::ADDR_W-1:0]        rd_addr,
    output logic signed [tse_pkg::WORD_W-1:0] key,
    input  tse_pkg::cmp_t                     cmp
);

    tse_pkg::state_t           state_reg, state_next;
    logic [tse_pkg::LEN_W-1:0] low_reg, low_next;
    logic [tse_pkg::LEN_W-1:0] hix_reg, hix_next;    // exclusive upper bound
    logic [tse_pkg::ADDR_W-1:0] probe_reg, probe_next;
    logic [tse_pkg::LEN_W-1:0] cmps_reg, cmps_next;
    logic                      bin_reg, bin_next;
    logic signed [tse_pkg::WORD_W-1:0] key_reg, key_next;
    tse_pkg::out_item_t        res_reg, res_next;
    logic                      out_valid_reg, out_valid_next;
    tse_pkg::out_item_t        out_reg, out_next;
    logic [tse_pkg::LEN_W:0]   mid_sum;
    logic                      accept;
    logic                      slot_free;

    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign mid_sum   = {1'b0, low_reg} + {1'b0, hix_reg} - {{tse_pkg::LEN_W{1'b0}}, 1'b1};

    assign in_stall  = (state_reg != tse_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign key       = key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tse_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg   <= low_next;
        hix_reg   <= hix_next;
        probe_reg <= probe_next;
        cmps_reg  <= cmps_next;
        bin_reg   <= bin_next;
        key_reg   <= key_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        hix_next       = hix_reg;
        probe_next     = probe_reg;
        cmps_next      = cmps_reg;
        bin_next       = bin_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        rd_en          = 1'b0;
        rd_addr        = low_reg[tse_pkg::ADDR_W-1:0];

        case (state_reg)
            tse_pkg::ST_IDLE:
            begin
                if (accept && (in_data.func == tse_pkg::FUNC_LINEAR ||
                               in_data.func == tse_pkg::FUNC_BINARY))
                begin
                    low_next   = '0;
                    hix_next   = search_len;
                    cmps_next  = '0;
                    bin_next   = (in_data.func == tse_pkg::FUNC_BINARY);
                    key_next   = in_data.search_key;
                    state_next = tse_pkg::ST_CHECK;
                end
            end
            tse_pkg::ST_CHECK:
            begin
                if (low_reg < hix_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = bin_reg ? mid_sum[tse_pkg::ADDR_W:1]
                                         : low_reg[tse_pkg::ADDR_W-1:0];
                    probe_next = rd_addr;
                    state_next = tse_pkg::ST_COMPARE;
                end
                else
                begin
                    res_next.found       = 1'b0;
                    res_next.position    = '0;
                    res_next.comparisons = cmps_reg;
                    state_next           = tse_pkg::ST_HOLD;
                end
            end
            tse_pkg::ST_COMPARE:
            begin
                cmps_next = cmps_reg + 1'b1;
                if (cmp.eq)
                begin
                    res_next.found       = 1'b1;
                    res_next.position    = probe_reg;
                    res_next.comparisons = cmps_next;
                    state_next           = tse_pkg::ST_HOLD;
                end
                else
                begin
                    // linear always steps past the probe; binary moves low or high
                    if (!bin_reg || cmp.lt)
                    begin
                        low_next = {1'b0, probe_reg} + 1'b1;
                    end
                    else
                    begin
                        hix_next = {1'b0, probe_reg};
                    end
                    state_next = tse_pkg::ST_CHECK;
                end
            end
            tse_pkg::ST_HOLD:
            begin
                // hold the result until the output word register frees up
                if (slot_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = tse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/table_search_engine_top.sv]
// Table search engine top level: length register, table RAM, comparator and sequencer.
// Depends on tse_pkg, tse_ram, tse_cmp and tse_ctrl.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_stall/in_data) carries load and query words.
//   A load (func 0) writes entry_value at entry_index and gives no result.
//   A linear (func 1) or binary (func 2) query searches the first table_length
//   entries for search_key; func 3 is dropped.
//   Output channel (out_valid/out_stall/out_data) returns found, position and
//   comparisons, one word per query.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes table_length; values
//   above 32 search the whole table. Write only while no query is running.
// Flow:
//   A load does not stall the input. A query makes one RAM read and one compare
//   per probe on the single read port and comparator: a read in ST_CHECK, then
//   a compare in ST_COMPARE; a hit or an empty range moves to ST_HOLD. The
//   result word becomes valid in the same cycle that the next word can enter.
//   in_stall is high from query accept until its result enters the output
//   register; a waiting result blocks the next word.
// Reset: table_length clears to 0, no result is pending; table contents are
//   undefined until loaded.
// Stall: a stalled output word holds; a finished query waits in the
//   sequencer and keeps the input stalled until the output register frees.

module table_search_engine_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  tse_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output tse_pkg::out_item_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tse_pkg::LEN_W-1:0]        cfg_data
);

    logic [tse_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [tse_pkg::LEN_W-1:0]         search_len;
    logic                              wr_en;
    logic                              rd_en;
    logic [tse_pkg::ADDR_W-1:0]        rd_addr;
    logic [tse_pkg::WORD_W-1:0]        rd_data;
    logic signed [tse_pkg::WORD_W-1:0] key;
    tse_pkg::cmp_t                     cmp;

    assign cfg_ready  = 1'b1;
    assign len_next   = (cfg_valid && cfg_ready) ? cfg_data : len_reg;
    assign search_len = (len_reg > tse_pkg::LEN_W'(tse_pkg::TABLE_DEPTH))
                        ? tse_pkg::LEN_W'(tse_pkg::TABLE_DEPTH) : len_reg;
    assign wr_en      = in_valid && !in_stall && (in_data.func == tse_pkg::FUNC_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    tse_ram #(
        .WIDTH (tse_pkg::WORD_W),
        .DEPTH (tse_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (in_data.entry_index[tse_pkg::ADDR_W-1:0]),
        .wdata (in_data.entry_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    tse_cmp u_cmp (
        .entry  ($signed(rd_data)),
        .key    (key),
        .result (cmp)
    );

    tse_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .search_len (search_len),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .key        (key),
        .cmp        (cmp)
    );

endmodule

[hdl/tse_checker.sv]
// Port-level checks for the table search engine, bound to the top level.
// Depends on tse_pkg and table_search_engine_top.
`timescale 1ns / 1ps

module tse_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input tse_pkg::in_item_t         in_data,
    input logic                      out_valid,
    input logic                      out_stall,
    input tse_pkg::out_item_t        out_data
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // an accepted query blocks the input while it runs
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.func == tse_pkg::FUNC_LINEAR ||
                                  in_data.func == tse_pkg::FUNC_BINARY) |=> in_stall)
        else $error("input not stalled after query accept");

    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.position == '0)
        else $error("miss reports a nonzero position");

    a_hit_cmps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> out_data.comparisons != '0)
        else $error("hit reports zero comparisons");

    a_cmps_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.comparisons <= 6'(tse_pkg::TABLE_DEPTH))
        else $error("comparison count exceeds table depth");

endmodule

bind table_search_engine_top tse_checker u_tse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[verif/table_search_engine_top_tb.sv]
// Self-checking testbench for table_search_engine_top: loads, linear and binary queries.
// Depends on tse_pkg and the table_search_engine_top RTL; keeps its own table copy to predict answers.
`timescale 1ns / 1ps

module table_search_engine_top_tb;

    import tse_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         ITEM_TARGET = 1350;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         DRAIN_WAIT  = 80;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    // Predicts one answer per query from a private copy of table and length
    class search_scoreboard;
        logic signed [WORD_W-1:0] entries [TABLE_DEPTH];
        logic [LEN_W-1:0]         length;
        out_item_t                expected_answers [$];
        int                       errors;

        function new();
            length = '0;
            errors = 0;
            foreach (entries[i])
                entries[i] = '0;
        endfunction

        function int live_length();
            return (length > TABLE_DEPTH) ? TABLE_DEPTH : int'(length);
        endfunction

        function out_item_t scan_linear(logic signed [WORD_W-1:0] key);
            out_item_t r;
            int        n;
            int        i;
            r = '0;
            n = live_length();
            for (i = 0; i < n; i++)
            begin
                r.comparisons = 6'(i + 1);
                if (entries[i] == key)
                begin
                    r.found    = 1'b1;
                    r.position = 5'(i);
                    return r;
                end
            end
            return r;
        endfunction

        function out_item_t scan_binary(logic signed [WORD_W-1:0] key);
            out_item_t r;
            int        lo;
            int        hi;
            int        mid;
            int        cmps;
            r    = '0;
            lo   = 0;
            hi   = live_length() - 1;
            cmps = 0;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                cmps++;
                if (entries[mid] == key)
                begin
                    r.found       = 1'b1;
                    r.position    = 5'(mid);
                    r.comparisons = 6'(cmps);
                    return r;
                end
                if (entries[mid] < key)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            r.comparisons = 6'(cmps);
            return r;
        endfunction

        function void note_word(in_item_t w);
            case (w.func)
                FUNC_LOAD:
                begin
                    if (w.entry_index < TABLE_DEPTH)
                        entries[w.entry_index] = w.entry_value;
                end
                FUNC_LINEAR: expected_answers.push_back(scan_linear(w.search_key));
                FUNC_BINARY: expected_answers.push_back(scan_binary(w.search_key));
                default: ;
            endcase
        endfunction

        task report(string what);
            if (errors < 40)
                $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_word(out_item_t got);
            out_item_t want;
            if (expected_answers.size() == 0)
            begin
                report($sformatf("unexpected word found=%0b position=%0d comparisons=%0d",
                                 got.found, got.position, got.comparisons));
                return;
            end
            want = expected_answers.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %0b, expected %0b", got.found, want.found));
            if (got.position !== want.position)
                report($sformatf("position %0d, expected %0d", got.position, want.position));
            if (got.comparisons !== want.comparisons)
                report($sformatf("comparisons %0d, expected %0d",
                                 got.comparisons, want.comparisons));
        endtask
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_item_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data  = '0;

    search_scoreboard sb;

    // Generator's own view of what has been loaded
    logic signed [WORD_W-1:0] shadow_vals [TABLE_DEPTH];
    bit [TABLE_DEPTH-1:0]     shadow_written;
    int                       cur_len;
    int                       items_sent;
    int                       in_calm;
    int                       stall_left;
    int                       calm_left;
    int                       stall_pick;
    int                       quiet_cycles;

    table_search_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Monitors: every handshake is seen at the edge where it completes
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_word(in_data);
        if (rst_n && out_valid && !out_stall)
            sb.check_word(out_data);
        if (rst_n && cfg_valid && cfg_ready)
            sb.length = cfg_data;
    end

    // Output backpressure: short bursts, rare long ones, and calm stretches
    always @(posedge clk)
    begin
        if (calm_left > 0)
        begin
            calm_left--;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 2)
            begin
                calm_left = $urandom_range(20, 150);
                out_stall <= 1'b0;
            end
            else if (stall_pick < 22)
            begin
                stall_left = (stall_pick < 4) ? $urandom_range(10, 40) : $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Fail when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] no handshake for %0d cycles", $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (in_calm > 0)
        begin
            in_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            in_calm = $urandom_range(20, 80);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic in_item_t make_word(logic [1:0] f, logic [4:0] idx,
                                           logic signed [WORD_W-1:0] val,
                                           logic signed [WORD_W-1:0] key);
        in_item_t w;
        w.func        = f;
        w.entry_index = idx;
        w.entry_value = val;
        w.search_key  = key;
        return w;
    endfunction

    // Keep valid high across back-to-back words; drop it only for a gap
    task automatic send_word(in_item_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_load(int idx, logic signed [WORD_W-1:0] val);
        shadow_vals[idx]    = val;
        shadow_written[idx] = 1'b1;
        items_sent++;
        send_word(make_word(FUNC_LOAD, 5'(idx), val, $urandom));
    endtask

    task automatic send_query(logic [1:0] f, logic signed [WORD_W-1:0] key);
        items_sent++;
        send_word(make_word(f, 5'($urandom_range(0, 31)), $urandom, key));
    endtask

    // Wait for every expected word, then let any trailing load finish
    task automatic settle(int extra);
        in_valid <= 1'b0;
        // let the monitor note the last accepted word first
        @(posedge clk);
        while (sb.expected_answers.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] len);
        settle(10);
        cfg_data  <= len;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_len = (len > TABLE_DEPTH) ? TABLE_DEPTH : int'(len);
    endtask

    function automatic bit all_written(int n);
        int i;
        for (i = 0; i < n; i++)
            if (!shadow_written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic fill_sorted(int n);
        longint cur;
        int     step_max;
        int     i;
        bit     force_top;
        cur       = ($urandom_range(0, 3) == 0) ? longint'(WORD_MIN)
                                                : longint'(int'($urandom)) / 2 - 64'sd1073741824;
        step_max  = ($urandom_range(0, 2) == 0) ? 2 :
                    ($urandom_range(0, 1) == 0) ? 5000 : 300000000;
        force_top = ($urandom_range(0, 6) == 0);
        for (i = 0; i < n; i++)
        begin
            if (force_top && i == n - 1)
                cur = longint'(WORD_MAX);
            send_load(i, cur[WORD_W-1:0]);
            cur += $urandom_range(0, step_max);
            if (cur > longint'(WORD_MAX))
                cur = longint'(WORD_MAX);
        end
    endtask

    task automatic fill_random(int n);
        int i;
        for (i = 0; i < n; i++)
            send_load(i, $urandom);
    endtask

    task automatic random_query();
        logic signed [WORD_W-1:0] key;
        logic [1:0]               f;
        int                       r;
        int                       idx;
        r   = $urandom_range(0, 99);
        idx = (cur_len > 0) ? $urandom_range(0, cur_len - 1) : 0;
        if (cur_len > 0 && r < 55)
            key = shadow_vals[idx];
        else if (cur_len > 0 && r < 75)
            key = shadow_vals[idx] + (r[0] ? 1 : -1);
        else if (r < 85)
            key = r[0] ? WORD_MIN : WORD_MAX;
        else
            key = $urandom;
        f = ($urandom_range(0, 99) < 55) ? FUNC_BINARY : FUNC_LINEAR;
        send_query(f, key);
    endtask

    task automatic run_phase(int len);
        int mode;
        int k;
        write_length(LEN_W'(len));
        mode = $urandom_range(0, 99);
        if (!all_written(cur_len) || mode < 60)
            fill_sorted(cur_len);
        else if (mode < 80)
            fill_random(cur_len);
        repeat ($urandom_range(4, 30))
        begin
            k = $urandom_range(0, 99);
            if (k < 6)
                send_load($urandom_range(0, 31), $urandom);
            else if (k < 9)
                send_word(make_word(FUNC_UNUSED, 5'($urandom), $urandom, $urandom));
            else
                random_query();
        end
    endtask

    function automatic int pick_length();
        int extremes [5];
        extremes = '{0, 1, 32, 33, 63};
        if ($urandom_range(0, 99) < 15)
            return extremes[$urandom_range(0, 4)];
        return $urandom_range(1, 32);
    endfunction

    initial
    begin
        int first_lengths [4];
        first_lengths  = '{63, 32, 1, 0};
        sb             = new();
        shadow_written = '0;
        cur_len        = 0;
        items_sent     = 0;
        in_calm        = 0;
        stall_left     = 0;
        calm_left      = 0;
        quiet_cycles   = 0;
        foreach (shadow_vals[i])
            shadow_vals[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero length after reset: no probes at all
        send_query(FUNC_LINEAR, WORD_MAX);
        send_query(FUNC_BINARY, WORD_MIN);
        // Unused function code with every bit set is dropped
        send_word(make_word(FUNC_UNUSED, '1, '1, '1));

        // Sorted extremes, plus the top index
        send_load(0, WORD_MIN);
        send_load(1, -1);
        send_load(2, 0);
        send_load(3, WORD_MAX);
        send_load(31, 32'sh5555_5555);
        write_length(4);
        send_query(FUNC_LINEAR, -1);
        send_query(FUNC_LINEAR, WORD_MAX);
        send_query(FUNC_LINEAR, 5);
        send_query(FUNC_BINARY, WORD_MIN);
        send_query(FUNC_BINARY, WORD_MAX);
        send_query(FUNC_BINARY, 1);

        // Break the order and follow the probes blindly
        send_load(1, WORD_MAX);
        send_query(FUNC_BINARY, 0);
        send_query(FUNC_BINARY, -1);

        foreach (first_lengths[i])
            run_phase(first_lengths[i]);
        while (items_sent < ITEM_TARGET)
            run_phase(pick_length());

        settle(DRAIN_WAIT);
        if (sb.errors == 0 && sb.expected_answers.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
